@@ rtl/core/fri_pkg.sv @@
// Package for the FASTA record indexer: beat types, field widths and character codes.
// Used by fri_out_fifo, fasta_record_indexer and tb_top; depends on nothing else.
package fri_pkg;

    localparam int POS_FIELD_W    = 40;
    localparam int IDX_FIELD_W    = 32;
    localparam int DEF_POS_BITS   = 40;
    localparam int DEF_COUNT_BITS = 32;

    localparam logic [7:0] CH_GT = 8'h3E;
    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_HT = 8'h09;
    localparam logic [7:0] CH_CR = 8'h0D;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_t;

    typedef struct packed {
        logic                   status;
        logic [IDX_FIELD_W-1:0] record_index;
        logic [POS_FIELD_W-1:0] header_offset;
        logic [POS_FIELD_W-1:0] name_length;
        logic [POS_FIELD_W-1:0] body_offset;
        logic [POS_FIELD_W-1:0] body_end;
        logic [POS_FIELD_W-1:0] residue_count;
        logic [POS_FIELD_W-1:0] error_position;
        logic                   last_of_run;
    } out_t;

    typedef struct packed {
        logic [1:0] cnt;
        out_t       first;
        out_t       second;
    } push_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SP) || (c inside {[CH_HT:CH_CR]});
    endfunction

endpackage

@@ rtl/core/fri_out_fifo.sv @@
// Four-entry result queue that takes up to two result beats per cycle and gives one while out_ready is high.
// Depends on fri_pkg for the result and push types.
module fri_out_fifo
(
    input  logic           clk,
    input  logic           rst_n,
    input  fri_pkg::push_t push,
    output logic           room,
    output logic           out_valid,
    input  logic           out_ready,
    output fri_pkg::out_t  out_data
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    fri_pkg::out_t  mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg;
    logic [AW-1:0]  rd_ptr_next;
    logic [AW:0]    count_reg;
    logic [AW:0]    count_next;
    logic           pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign room      = (count_reg <= (AW+1)'(DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + AW'(push.cnt);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        count_next  = count_reg + (AW+1)'(push.cnt) - (AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.cnt == 2'd2)
        begin
            mem_reg[wr_ptr_reg + AW'(1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/core/fasta_record_indexer.sv @@
// Top level of the FASTA record indexer: per-byte parser state and result formation.
// Depends on fri_pkg and instantiates fri_out_fifo for the result beats.
//
//   channel | signals                       | beat
//   in      | in_valid, in_ready, in_data   | one text byte and its end-of-file flag
//   out     | out_valid, out_ready, out_data| one record or error result
//
// A byte is parsed in the cycle it is accepted, one byte per cycle sustained while the queue has room.
// Its zero, one or two results enter a four-entry queue that feeds the output.
// in_ready drops only while the queue lacks room for two results.
// Reset returns the parser to the start of a file and empties the queue.
module fasta_record_indexer
#(
    parameter int POS_BITS   = fri_pkg::DEF_POS_BITS,
    parameter int COUNT_BITS = fri_pkg::DEF_COUNT_BITS
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  fri_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output fri_pkg::out_t out_data
);

    localparam int PW = fri_pkg::POS_FIELD_W;
    localparam int IW = fri_pkg::IDX_FIELD_W;

    localparam logic [2:0] PH_SEEK = 3'd0;
    localparam logic [2:0] PH_NAME = 3'd1;
    localparam logic [2:0] PH_HDR  = 3'd2;
    localparam logic [2:0] PH_SEQ  = 3'd3;
    localparam logic [2:0] PH_ERR  = 3'd4;

    localparam logic [POS_BITS-1:0]   POS_MAX = '1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [2:0]            phase_reg;
    logic [2:0]            phase_next;
    logic [POS_BITS-1:0]   pos_reg;
    logic [POS_BITS-1:0]   pos_next;
    logic [POS_BITS-1:0]   hdr_reg;
    logic [POS_BITS-1:0]   hdr_next;
    logic [POS_BITS-1:0]   nlen_reg;
    logic [POS_BITS-1:0]   nlen_next;
    logic [POS_BITS-1:0]   doff_reg;
    logic [POS_BITS-1:0]   doff_next;
    logic [POS_BITS-1:0]   res_reg;
    logic [POS_BITS-1:0]   res_next;
    logic [COUNT_BITS-1:0] recs_reg;
    logic [COUNT_BITS-1:0] recs_next;

    logic                  accept;
    logic                  ws;
    logic [POS_BITS-1:0]   nxt;
    fri_pkg::push_t        push;
    logic                  room;

    function automatic fri_pkg::out_t make_rec(
        input logic [COUNT_BITS-1:0] idx,
        input logic [POS_BITS-1:0]   hdr,
        input logic [POS_BITS-1:0]   nlen,
        input logic [POS_BITS-1:0]   doff,
        input logic [POS_BITS-1:0]   dend,
        input logic [POS_BITS-1:0]   res
    );
        fri_pkg::out_t r;
        r                = '0;
        r.record_index   = IW'(idx);
        r.header_offset  = PW'(hdr);
        r.name_length    = PW'(nlen);
        r.body_offset    = PW'(doff);
        r.body_end       = PW'(dend);
        r.residue_count  = PW'(res);
        return r;
    endfunction

    function automatic logic [POS_BITS-1:0] pos_inc(input logic [POS_BITS-1:0] x);
        return (x == POS_MAX) ? x : x + POS_BITS'(1);
    endfunction

    function automatic logic [COUNT_BITS-1:0] cnt_inc(input logic [COUNT_BITS-1:0] x);
        return (x == CNT_MAX) ? x : x + COUNT_BITS'(1);
    endfunction

    assign in_ready = room;
    assign accept   = in_valid && in_ready;
    assign ws       = fri_pkg::is_ws(in_data.data_byte);
    assign nxt      = pos_inc(pos_reg);

    always_comb
    begin
        fri_pkg::out_t r0;
        fri_pkg::out_t r1;
        logic [1:0]    n;

        phase_next = phase_reg;
        hdr_next   = hdr_reg;
        nlen_next  = nlen_reg;
        doff_next  = doff_reg;
        res_next   = res_reg;
        recs_next  = recs_reg;
        r0         = '0;
        r1         = '0;
        n          = 2'd0;

        case (phase_reg)
            PH_SEEK:
            begin
                if (!ws)
                begin
                    if (in_data.data_byte == fri_pkg::CH_GT)
                    begin
                        hdr_next   = pos_reg;
                        nlen_next  = '0;
                        doff_next  = '0;
                        res_next   = '0;
                        phase_next = PH_NAME;
                    end
                    else
                    begin
                        r0.status         = 1'b1;
                        r0.error_position = PW'(pos_reg);
                        n                 = 2'd1;
                        phase_next        = PH_ERR;
                    end
                end
            end
            PH_NAME:
            begin
                if (!ws)
                begin
                    nlen_next = pos_inc(nlen_reg);
                end
                else if (in_data.data_byte == fri_pkg::CH_NL)
                begin
                    doff_next  = nxt;
                    res_next   = '0;
                    phase_next = PH_SEQ;
                end
                else
                begin
                    phase_next = PH_HDR;
                end
            end
            PH_HDR:
            begin
                if (in_data.data_byte == fri_pkg::CH_NL)
                begin
                    doff_next  = nxt;
                    res_next   = '0;
                    phase_next = PH_SEQ;
                end
            end
            PH_SEQ:
            begin
                if (in_data.data_byte == fri_pkg::CH_GT)
                begin
                    r0         = make_rec(recs_reg, hdr_reg, nlen_reg, doff_reg,
                                          pos_reg, res_reg);
                    n          = 2'd1;
                    recs_next  = cnt_inc(recs_reg);
                    hdr_next   = pos_reg;
                    nlen_next  = '0;
                    doff_next  = '0;
                    res_next   = '0;
                    phase_next = PH_NAME;
                end
                else if (!ws)
                begin
                    res_next = pos_inc(res_reg);
                end
            end
            default:
            begin
                phase_next = PH_ERR;
            end
        endcase

        pos_next = nxt;

        if (in_data.final_byte)
        begin
            if (phase_next == PH_NAME || phase_next == PH_HDR || phase_next == PH_SEQ)
            begin
                if (phase_next != PH_SEQ)
                begin
                    doff_next = nxt;
                    res_next  = '0;
                end
                if (n == 2'd0)
                begin
                    r0 = make_rec(recs_next, hdr_next, nlen_next, doff_next, nxt, res_next);
                end
                else
                begin
                    r1 = make_rec(recs_next, hdr_next, nlen_next, doff_next, nxt, res_next);
                end
                n = n + 2'd1;
            end
            phase_next = PH_SEEK;
            pos_next   = '0;
            hdr_next   = '0;
            nlen_next  = '0;
            doff_next  = '0;
            res_next   = '0;
            recs_next  = '0;
        end

        if (n == 2'd2)
        begin
            r1.last_of_run = 1'b1;
        end
        else
        begin
            r0.last_of_run = 1'b1;
        end

        push.cnt    = accept ? n : 2'd0;
        push.first  = r0;
        push.second = r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEEK;
            pos_reg   <= '0;
            hdr_reg   <= '0;
            nlen_reg  <= '0;
            doff_reg  <= '0;
            res_reg   <= '0;
            recs_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            hdr_reg   <= hdr_next;
            nlen_reg  <= nlen_next;
            doff_reg  <= doff_next;
            res_reg   <= res_next;
            recs_reg  <= recs_next;
        end
    end

    fri_out_fifo u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for fasta_record_indexer: byte stimulus, a scoreboard class
// that predicts record and error results, and random idling on both channels.
// Depends on fri_pkg and the RTL of fasta_record_indexer.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 16;
    localparam int ITEM_TARGET = 1000;

    localparam int PW = fri_pkg::POS_FIELD_W;
    localparam int IW = fri_pkg::IDX_FIELD_W;

    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;

    typedef enum logic [2:0] {
        P_SEEK,
        P_NAME,
        P_HDR,
        P_SEQ,
        P_ERR
    } parse_phase_t;

    class record_scoreboard;
        parse_phase_t               phase;
        logic [PW-1:0]              pos;
        logic [PW-1:0]              hdr_off;
        logic [PW-1:0]              name_len;
        logic [PW-1:0]              body_off;
        logic [PW-1:0]              res_cnt;
        logic [IW-1:0]              rec_cnt;
        fri_pkg::out_t              batch[$];
        fri_pkg::out_t              pending_q[$];
        int                         errors;
        int                         results_made;

        function new();
            errors = 0;
            results_made = 0;
            restart();
        endfunction

        static function bit is_blank(logic [7:0] c);
            return (c == fri_pkg::CH_SP) || (c >= fri_pkg::CH_HT && c <= fri_pkg::CH_CR);
        endfunction

        function logic [PW-1:0] pos_inc(logic [PW-1:0] x);
            return (x == '1) ? x : x + PW'(1);
        endfunction

        function void restart();
            phase = P_SEEK;
            pos = '0;
            hdr_off = '0;
            name_len = '0;
            body_off = '0;
            res_cnt = '0;
            rec_cnt = '0;
        endfunction

        function void open_record(logic [PW-1:0] at);
            hdr_off = at;
            name_len = '0;
            body_off = '0;
            res_cnt = '0;
            phase = P_NAME;
        endfunction

        function void begin_body(logic [PW-1:0] at);
            body_off = at;
            res_cnt = '0;
            phase = P_SEQ;
        endfunction

        function void close_record(logic [PW-1:0] end_at);
            fri_pkg::out_t r;
            r = '0;
            r.record_index = rec_cnt;
            r.header_offset = hdr_off;
            r.name_length = name_len;
            r.body_offset = body_off;
            r.body_end = end_at;
            r.residue_count = res_cnt;
            batch.insert(batch.size(), r);
            if (rec_cnt != '1)
                rec_cnt = rec_cnt + IW'(1);
        endfunction

        // Returns 1 when the beat is not simply ignored by the error phase.
        function bit note_byte(fri_pkg::in_t beat);
            logic [7:0]             c;
            logic [PW-1:0]          here;
            logic [PW-1:0]          next;
            bit                     ws;
            bit                     useful;
            fri_pkg::out_t          r;
            c = beat.data_byte;
            here = pos;
            next = pos_inc(pos);
            ws = is_blank(c);
            useful = (phase != P_ERR);
            batch.delete();
            case (phase)
                P_SEEK:
                begin
                    if (!ws)
                    begin
                        if (c == fri_pkg::CH_GT)
                        begin
                            open_record(here);
                        end
                        else
                        begin
                            r = '0;
                            r.status = 1'b1;
                            r.error_position = here;
                            batch.insert(batch.size(), r);
                            phase = P_ERR;
                        end
                    end
                end
                P_NAME:
                begin
                    if (!ws)
                        name_len = pos_inc(name_len);
                    else if (c == fri_pkg::CH_NL)
                        begin_body(next);
                    else
                        phase = P_HDR;
                end
                P_HDR:
                begin
                    if (c == fri_pkg::CH_NL)
                        begin_body(next);
                end
                P_SEQ:
                begin
                    if (c == fri_pkg::CH_GT)
                    begin
                        close_record(here);
                        open_record(here);
                    end
                    else if (!ws)
                    begin
                        res_cnt = pos_inc(res_cnt);
                    end
                end
                default:
                begin
                    phase = P_ERR;
                end
            endcase
            pos = next;
            if (beat.final_byte)
            begin
                if (phase == P_NAME || phase == P_HDR)
                begin
                    body_off = next;
                    res_cnt = '0;
                    close_record(next);
                end
                else if (phase == P_SEQ)
                begin
                    close_record(next);
                end
                restart();
            end
            if (batch.size() > 0)
                batch[batch.size()-1].last_of_run = 1'b1;
            foreach (batch[i])
                pending_q.insert(pending_q.size(), batch[i]);
            results_made += batch.size();
            return useful;
        endfunction

        task report(string field, logic [63:0] got, logic [63:0] want);
            if (errors < 100)
                $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field,
                         got, want);
            errors++;
        endtask

        task check_result(fri_pkg::out_t got);
            fri_pkg::out_t want;
            if (pending_q.size() == 0)
            begin
                report("unexpected result beat", 64'(got.record_index), 64'(0));
                return;
            end
            want = pending_q.pop_front();
            if (got.status !== want.status)
                report("status", 64'(got.status), 64'(want.status));
            if (got.record_index !== want.record_index)
                report("record_index", 64'(got.record_index), 64'(want.record_index));
            if (got.header_offset !== want.header_offset)
                report("header_offset", 64'(got.header_offset), 64'(want.header_offset));
            if (got.name_length !== want.name_length)
                report("name_length", 64'(got.name_length), 64'(want.name_length));
            if (got.body_offset !== want.body_offset)
                report("body_offset", 64'(got.body_offset), 64'(want.body_offset));
            if (got.body_end !== want.body_end)
                report("body_end", 64'(got.body_end), 64'(want.body_end));
            if (got.residue_count !== want.residue_count)
                report("residue_count", 64'(got.residue_count), 64'(want.residue_count));
            if (got.error_position !== want.error_position)
                report("error_position", 64'(got.error_position), 64'(want.error_position));
            if (got.last_of_run !== want.last_of_run)
                report("last_of_run", 64'(got.last_of_run), 64'(want.last_of_run));
        endtask

        function int outstanding();
            return pending_q.size();
        endfunction
    endclass

    logic          clk = 1'b0;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    fri_pkg::in_t  in_data;
    logic          out_valid;
    logic          out_ready;
    fri_pkg::out_t out_data;

    record_scoreboard sb;
    int   send_idle_pct = 17;
    int   recv_stall_pct = 86;
    int   sent_items = 0;
    int   hold_left = 0;
    bit   hold_req = 1'b0;
    int   stall_cycles = 0;

    fasta_record_indexer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [7:0] blank_byte(bit allow_nl);
        case ($urandom_range(allow_nl ? 5 : 4))
            0: return fri_pkg::CH_SP;
            1: return fri_pkg::CH_HT;
            2: return CH_VT;
            3: return CH_FF;
            4: return fri_pkg::CH_CR;
            default: return fri_pkg::CH_NL;
        endcase
    endfunction

    function automatic logic [7:0] solid_byte(bit no_gt);
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (record_scoreboard::is_blank(b) || (no_gt && b == fri_pkg::CH_GT));
        return b;
    endfunction

    function automatic logic [7:0] header_byte();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == fri_pkg::CH_NL);
        return b;
    endfunction

    function automatic logic [7:0] residue_byte();
        string bases;
        int    pick;
        bases = "ACGTNacgtn";
        pick = $urandom_range(99);
        if (pick < 70)
            return bases[$urandom_range(9)];
        else if (pick < 90)
            return solid_byte(1'b1);
        else
            return blank_byte(1'b0);
    endfunction

    task automatic send_byte(logic [7:0] b, logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= fri_pkg::in_t'{data_byte: b, final_byte: fin};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (sb.note_byte(fri_pkg::in_t'{data_byte: b, final_byte: fin}))
            sent_items++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    task automatic send_random_file();
        logic [7:0] text[$];
        int         kind;
        int         cut;
        kind = $urandom_range(99);
        if (kind >= 88)
        begin
            repeat ($urandom_range(12, 1))
                text.insert(text.size(), 8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(2))
                text.insert(text.size(), blank_byte(1'b1));
            repeat ($urandom_range(4, 1))
            begin
                text.insert(text.size(), fri_pkg::CH_GT);
                repeat ($urandom_range(6))
                    text.insert(text.size(), solid_byte(1'b0));
                if ($urandom_range(1))
                begin
                    text.insert(text.size(), blank_byte(1'b0));
                    repeat ($urandom_range(8))
                        text.insert(text.size(), header_byte());
                end
                text.insert(text.size(), fri_pkg::CH_NL);
                repeat ($urandom_range(3))
                begin
                    repeat ($urandom_range(12))
                        text.insert(text.size(), residue_byte());
                    text.insert(text.size(), fri_pkg::CH_NL);
                end
            end
            if (kind >= 75)
            begin
                cut = $urandom_range(text.size(), 1);
                while (text.size() > cut)
                    void'(text.pop_back());
            end
        end
        foreach (text[i])
            send_byte(text[i], i == text.size() - 1);
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_text(">a\014b\nC T\n>");
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_text(" \015>nm");
        send_text("\013>a\t");
        send_text(">\n");
        send_text(" ");

        while (sent_items < ITEM_TARGET)
        begin
            if (sent_items >= 2 * ITEM_TARGET / 3)
            begin
                if (send_idle_pct != 0 || recv_stall_pct != 0)
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    hold_req = 1'b1;
                end
            end
            else if (sent_items >= ITEM_TARGET / 3)
            begin
                send_idle_pct = 86;
                recv_stall_pct = 17;
            end
            send_random_file();
        end
        in_valid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("[fasta_record_indexer] OK");
        else
            $display("[fasta_record_indexer] ERROR");
        $finish;
    end

    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result(out_data);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[fasta_record_indexer] ERROR");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
